@@ hdl/assert_macros.svh @@
// Assertion macros shared by the addback RTL.
// Clock clk_i and active-low reset rst_ni are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CCA_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define CCA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ hdl/cca_pkg.sv @@
// Package for the clover crystal addback block: widths, request types, pair tables.
// No dependencies.
package cca_pkg;

  localparam int N  = 4;                 // crystals per group
  localparam int NP = N * (N - 1) / 2;   // unordered crystal pairs
  localparam int IW = $clog2(N);
  localparam int EW = 20;                // input energy
  localparam int SW = 22;                // summed energy
  localparam int TW = 32;                // timestamp
  localparam int DW = TW + 1;            // exact stamp difference
  localparam int WW = 16;                // coincidence window
  localparam int CW = 3;                 // survivor count
  localparam int TOTW = SW + IW;         // total of all sums

  localparam logic [WW-1:0] WINDOW_RESET = WW'(120);

  typedef struct packed {
    logic        [EW-1:0] energy_a;
    logic        [EW-1:0] energy_b;
    logic        [EW-1:0] energy_c;
    logic        [EW-1:0] energy_d;
    logic signed [TW-1:0] stamp_a;
    logic signed [TW-1:0] stamp_b;
    logic signed [TW-1:0] stamp_c;
    logic signed [TW-1:0] stamp_d;
  } in_req_t;

  typedef struct packed {
    logic        [SW-1:0] summed_a;
    logic        [SW-1:0] summed_b;
    logic        [SW-1:0] summed_c;
    logic        [SW-1:0] summed_d;
    logic signed [TW-1:0] kept_a;
    logic signed [TW-1:0] kept_b;
    logic signed [TW-1:0] kept_c;
    logic signed [TW-1:0] kept_d;
    logic        [CW-1:0] survivors;
  } out_req_t;

  // after the subtract stage
  typedef struct packed {
    logic [N-1:0][EW-1:0]  orig;
    logic [N-1:0][TW-1:0]  stamp;
    logic [NP-1:0]         ge;
    logic [NP-1:0][DW-1:0] diff;
  } diff_t;

  // running addback state
  typedef struct packed {
    logic [N-1:0][SW-1:0] sum;
    logic [N-1:0][TW-1:0] stamp;
    logic [NP-1:0]        ge;
    logic [NP-1:0]        near;
  } work_t;

  // lower crystal index of pair p, pairs in visiting order
  function automatic int pair_lo(input int p);
    int n;
    int r;
    n = 0;
    r = 0;
    for (int j = 0; j < N; j++) begin
      for (int k = j + 1; k < N; k++) begin
        if (n == p) r = j;
        n++;
      end
    end
    return r;
  endfunction

  function automatic int pair_hi(input int p);
    int n;
    int r;
    n = 0;
    r = 0;
    for (int j = 0; j < N; j++) begin
      for (int k = j + 1; k < N; k++) begin
        if (n == p) r = k;
        n++;
      end
    end
    return r;
  endfunction

  // pairs whose lower index is zero go in the first merge stage
  function automatic logic [NP-1:0] first_pairs();
    logic [NP-1:0] m;
    m = '0;
    for (int p = 0; p < NP; p++) m[p] = (pair_lo(p) == 0);
    return m;
  endfunction

endpackage

@@ hdl/cca_merge_stage.sv @@
// One registered merge stage: applies the selected pairs in order to the running sums.
// Depends on cca_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cca_merge_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cca_pkg::NP-1:0]     pairs_i,
  input  logic                       up_valid_i,
  output logic                       up_ready_o,
  input  cca_pkg::work_t             work_i,
  output logic                       dn_valid_o,
  input  logic                       dn_ready_i,
  output cca_pkg::work_t             work_o
);

  cca_pkg::work_t             work_d;
  cca_pkg::work_t             work_q;
  logic                       valid_q;
  logic [cca_pkg::TOTW-1:0]   tot_in;
  logic [cca_pkg::TOTW-1:0]   tot_out;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign dn_valid_o = valid_q;
  assign work_o     = work_q;

  always_comb begin
    logic [cca_pkg::IW-1:0] j;
    logic [cca_pkg::IW-1:0] k;
    work_d = work_i;
    for (int p = 0; p < cca_pkg::NP; p++) begin
      j = cca_pkg::IW'(cca_pkg::pair_lo(p));
      k = cca_pkg::IW'(cca_pkg::pair_hi(p));
      if (pairs_i[p] && work_d.near[p] && (work_d.sum[j] != '0) && (work_d.sum[k] != '0)) begin
        if (work_d.ge[p]) begin
          work_d.sum[j] = work_d.sum[j] + work_d.sum[k];
          work_d.sum[k] = '0;
        end else begin
          work_d.sum[k] = work_d.sum[k] + work_d.sum[j];
          work_d.sum[j] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      work_q <= work_d;
    end
  end

  // energy totals, for the conservation check
  always_comb begin
    tot_in  = '0;
    tot_out = '0;
    for (int c = 0; c < cca_pkg::N; c++) begin
      tot_in  = tot_in + cca_pkg::TOTW'(work_i.sum[c]);
      tot_out = tot_out + cca_pkg::TOTW'(work_q.sum[c]);
    end
  end

  `CCA_ASSERT_NEXT(a_energy_kept, up_valid_i && up_ready_o, tot_out == $past(tot_in))
  `CCA_ASSERT_NEXT(a_held_stage, dn_valid_o && !dn_ready_i, dn_valid_o && $stable(work_o))

endmodule

@@ hdl/clover_crystal_addback.sv @@
// Top level of the clover crystal addback block.
// Depends on cca_pkg, cca_merge_stage and assert_macros.svh.
//
// Usage
//   Input channel (in_valid_i / in_stall_o / in_req_i) carries one group request:
//   four crystal energies (zero = no hit) and four signed timestamps.
//   Output channel (out_valid_o / out_stall_i / out_req_o) returns one request per
//   input: summed energies, survivor times (zero if absorbed or empty) and the
//   survivor count. A request moves when valid is high and stall is low.
//   cfg_we_i / cfg_wdata_i write the coincidence window; write only when idle.
// Timing
//   Five register stages: stamp subtract, window compare, merges of the pairs led
//   by crystal 0, merges of the remaining pairs, output register. A result is
//   offered from the output register once it has passed through the stages before it;
//   one request per cycle sustained while out_stall_i is low.
//   The pair chain of the merge stages (three dependent 22-bit adds) sets the depth.
// Reset
//   rst_ni (async, active low) empties the pipe and sets the window to 120.
// Stall
//   Each stage holds when its successor is full and held, so out_stall_i backs up
//   stage by stage; empty stages still fill and nothing is dropped or repeated.
`include "assert_macros.svh"

module clover_crystal_addback (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [cca_pkg::WW-1:0]   cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  cca_pkg::in_req_t         in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output cca_pkg::out_req_t        out_req_o
);

  logic [cca_pkg::WW-1:0] window_q;

  cca_pkg::diff_t    s1_d, s1_q;
  logic              s1_valid_q, s1_ready;
  cca_pkg::work_t    s2_d, s2_q;
  logic              s2_valid_q, s2_ready;
  cca_pkg::work_t    ma_work, mb_work;
  logic              ma_valid, ma_ready_up, mb_valid, mb_ready_up;
  cca_pkg::out_req_t out_d, out_q;
  logic              out_valid_q, out_ready;

  // coincidence window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= cca_pkg::WINDOW_RESET;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  // stage ready chain
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || ma_ready_up;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  // stage 1: exact 33-bit stamp differences and original energy order
  always_comb begin
    logic [cca_pkg::IW-1:0] j;
    logic [cca_pkg::IW-1:0] k;
    s1_d.orig[0]  = in_req_i.energy_a;
    s1_d.orig[1]  = in_req_i.energy_b;
    s1_d.orig[2]  = in_req_i.energy_c;
    s1_d.orig[3]  = in_req_i.energy_d;
    s1_d.stamp[0] = in_req_i.stamp_a;
    s1_d.stamp[1] = in_req_i.stamp_b;
    s1_d.stamp[2] = in_req_i.stamp_c;
    s1_d.stamp[3] = in_req_i.stamp_d;
    for (int p = 0; p < cca_pkg::NP; p++) begin
      j = cca_pkg::IW'(cca_pkg::pair_lo(p));
      k = cca_pkg::IW'(cca_pkg::pair_hi(p));
      s1_d.ge[p]   = s1_d.orig[j] >= s1_d.orig[k];
      s1_d.diff[p] = {s1_d.stamp[j][cca_pkg::TW-1], s1_d.stamp[j]}
                   - {s1_d.stamp[k][cca_pkg::TW-1], s1_d.stamp[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: -window <= diff <= window, both bounds compared in parallel
  always_comb begin
    logic signed [cca_pkg::DW-1:0] wpos;
    logic signed [cca_pkg::DW-1:0] wneg;
    wpos = $signed({{(cca_pkg::DW - cca_pkg::WW){1'b0}}, window_q});
    wneg = -wpos;
    for (int c = 0; c < cca_pkg::N; c++) begin
      s2_d.sum[c] = cca_pkg::SW'(s1_q.orig[c]);
    end
    s2_d.stamp = s1_q.stamp;
    s2_d.ge    = s1_q.ge;
    for (int p = 0; p < cca_pkg::NP; p++) begin
      s2_d.near[p] = ($signed(s1_q.diff[p]) <= wpos) && ($signed(s1_q.diff[p]) >= wneg);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  // stages 3 and 4: pairs in visiting order, split where the lower index moves on from crystal 0
  cca_merge_stage u_merge_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pairs_i    (cca_pkg::first_pairs()),
    .up_valid_i (s2_valid_q),
    .up_ready_o (ma_ready_up),
    .work_i     (s2_q),
    .dn_valid_o (ma_valid),
    .dn_ready_i (mb_ready_up),
    .work_o     (ma_work)
  );

  cca_merge_stage u_merge_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pairs_i    (~cca_pkg::first_pairs()),
    .up_valid_i (ma_valid),
    .up_ready_o (mb_ready_up),
    .work_i     (ma_work),
    .dn_valid_o (mb_valid),
    .dn_ready_i (out_ready),
    .work_o     (mb_work)
  );

  // stage 5: survivors keep their time, absorbed or empty crystals read zero
  always_comb begin
    logic [cca_pkg::N-1:0]  alive;
    logic [cca_pkg::CW-1:0] cnt;
    cnt = '0;
    for (int c = 0; c < cca_pkg::N; c++) begin
      alive[c] = mb_work.sum[c] != '0;
      cnt      = cnt + cca_pkg::CW'(alive[c]);
    end
    out_d.summed_a  = mb_work.sum[0];
    out_d.summed_b  = mb_work.sum[1];
    out_d.summed_c  = mb_work.sum[2];
    out_d.summed_d  = mb_work.sum[3];
    out_d.kept_a    = alive[0] ? mb_work.stamp[0] : '0;
    out_d.kept_b    = alive[1] ? mb_work.stamp[1] : '0;
    out_d.kept_c    = alive[2] ? mb_work.stamp[2] : '0;
    out_d.kept_d    = alive[3] ? mb_work.stamp[3] : '0;
    out_d.survivors = cnt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= mb_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && mb_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `CCA_ASSERT_NOW(a_count_range, out_valid_o, out_req_o.survivors <= cca_pkg::CW'(cca_pkg::N))
  `CCA_ASSERT_NOW(a_absorbed_no_time, out_valid_o && (out_req_o.summed_a == '0), out_req_o.kept_a == '0)

endmodule
